// ===== src/gcd_and_lcm_unit_defines.svh =====
// ----------------------------------------------------------------------------
// GCD and LCM unit assertion macros
// Shared property templates for the checker of the GCD and LCM unit.
// ----------------------------------------------------------------------------
`ifndef GCD_AND_LCM_UNIT_DEFINES_SVH
`define GCD_AND_LCM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GAL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcd_and_lcm_unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define GAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcd_and_lcm_unit: next-cycle check failed");

`endif

// ===== src/gal_pkg.sv =====
// ----------------------------------------------------------------------------
// GCD and LCM unit package
// Types and fixed field widths shared by the GCD and LCM unit files.
// ----------------------------------------------------------------------------
package gal_pkg;

  localparam int unsigned FIELD_W     = 32;  // operand and gcd field width
  localparam int unsigned LCM_W       = 64;  // lcm field width
  localparam int unsigned IN_TDATA_W  = 2 * FIELD_W;
  localparam int unsigned OUT_TDATA_W = FIELD_W + LCM_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EUC,
    ST_EUC_WAIT,
    ST_LCM_WAIT,
    ST_MUL,
    ST_DONE
  } gal_state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } gal_div_sts_t;

endpackage

// ===== src/gal_div.sv =====
// ----------------------------------------------------------------------------
// GCD and LCM unit divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gal_div #(
  parameter int unsigned W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [W-1:0]         dividend,
  input  logic [W-1:0]         divisor,
  output logic [W-1:0]         quotient,
  output logic [W-1:0]         remainder,
  output gal_pkg::gal_div_sts_t sts
);
  import gal_pkg::*;

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract when it fits
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign sts.busy  = busy_r;
  assign sts.done  = done_r;

endmodule

// ===== src/gcd_and_lcm_unit.sv =====
// ----------------------------------------------------------------------------
// GCD and LCM unit
// Greatest common divisor by Euclid's remainder rule and least common
// multiple as (a / gcd) * b, on one shared iterative divider.
// ----------------------------------------------------------------------------
// The unit takes one request of two unsigned operands and returns one result
// holding their gcd, their lcm and a flag for the case of both operands zero
// (then gcd and lcm are both 0). Only the low OPERAND_WIDTH bits of each
// operand are used; above 32 all 32 bits of the field take part, and the lcm
// then always fits its 64 bits. The Euclid loop takes k remainder steps,
// with k at most 46 for 32-bit operands; a request with both operands zero
// skips the divider. The single restoring divider produces one quotient bit
// per cycle and serves every Euclid remainder as well as the final a / gcd.
// The unit holds in_tready low from the accepted request until its result
// moves to the output register; the next request is taken while a result
// still waits there.
module gcd_and_lcm_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // slave side
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gal_pkg::IN_TDATA_W-1:0]   in_tdata,   // operand_a, operand_b
  // master side
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gal_pkg::OUT_TDATA_W-1:0]  out_tdata,  // gcd_value, lcm_value
  output logic                             out_tuser   // both_zero
);
  import gal_pkg::*;

  // used operand width: the input fields carry no more than FIELD_W bits
  localparam int unsigned OW = (OPERAND_WIDTH < FIELD_W) ? OPERAND_WIDTH : FIELD_W;

  gal_state_t state_r, state_nxt;

  logic [OW-1:0]   a_r, a_nxt;        // masked operand a, kept for a / gcd
  logic [OW-1:0]   b_r, b_nxt;        // masked operand b, kept for the product
  logic [OW-1:0]   x_r, x_nxt;        // Euclid pair
  logic [OW-1:0]   y_r, y_nxt;
  logic [OW-1:0]   g_r, g_nxt;        // gcd
  logic [OW-1:0]   quo_r, quo_nxt;    // a / gcd
  logic [2*OW-1:0] prod_r, prod_nxt;  // lcm
  logic            zero_r, zero_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]  out_gcd_r, out_gcd_nxt;
  logic [LCM_W-1:0]    out_lcm_r, out_lcm_nxt;
  logic                out_zero_r, out_zero_nxt;

  logic [OW-1:0] op_a;
  logic [OW-1:0] op_b;

  // shared divider
  logic          div_start;
  logic [OW-1:0] div_dividend;
  logic [OW-1:0] div_divisor;
  logic [OW-1:0] div_quo;
  logic [OW-1:0] div_rem;
  gal_div_sts_t  div_sts;

  gal_div #(
    .W (OW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .sts       (div_sts)
  );

  // drop operand bits above the used width
  assign op_a = in_tdata[OW-1:0];
  assign op_b = in_tdata[FIELD_W +: OW];

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    g_nxt         = g_r;
    quo_nxt       = quo_r;
    prod_nxt      = prod_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    out_gcd_nxt   = out_gcd_r;
    out_lcm_nxt   = out_lcm_r;
    out_zero_nxt  = out_zero_r;
    div_start     = 1'b0;
    div_dividend  = x_r;
    div_divisor   = y_r;

    // retire the waiting result once the sink takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          a_nxt    = op_a;
          b_nxt    = op_b;
          x_nxt    = op_a;
          y_nxt    = op_b;
          zero_nxt = (op_a == '0) && (op_b == '0);
          if ((op_a == '0) && (op_b == '0)) begin
            // both zero: gcd and lcm are 0, skip the divider
            g_nxt     = '0;
            prod_nxt  = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_EUC;
          end
        end
      end
      ST_EUC: begin
        div_start = 1'b1;
        if (y_r == '0) begin
          // Euclid finished: x holds the gcd, now form a / gcd
          g_nxt        = x_r;
          div_dividend = a_r;
          div_divisor  = x_r;
          state_nxt    = ST_LCM_WAIT;
        end else begin
          state_nxt = ST_EUC_WAIT;
        end
      end
      ST_EUC_WAIT: begin
        if (div_sts.done) begin
          x_nxt     = y_r;
          y_nxt     = div_rem;
          state_nxt = ST_EUC;
        end
      end
      ST_LCM_WAIT: begin
        if (div_sts.done) begin
          quo_nxt   = div_quo;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = {{OW{1'b0}}, quo_r} * {{OW{1'b0}}, b_r};
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_gcd_nxt   = FIELD_W'(g_r);
          out_lcm_nxt   = LCM_W'(prod_r);
          out_zero_nxt  = zero_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    g_r        <= g_nxt;
    quo_r      <= quo_nxt;
    prod_r     <= prod_nxt;
    zero_r     <= zero_nxt;
    out_gcd_r  <= out_gcd_nxt;
    out_lcm_r  <= out_lcm_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_lcm_r, out_gcd_r};
  assign out_tuser  = out_zero_r;

endmodule

// ===== src/gal_checker.sv =====
// ----------------------------------------------------------------------------
// GCD and LCM unit checker
// Port-level assertions on the GCD and LCM unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "gcd_and_lcm_unit_defines.svh"

module gal_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [gal_pkg::IN_TDATA_W-1:0]   in_tdata,   // operand_a, operand_b
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [gal_pkg::OUT_TDATA_W-1:0]  out_tdata,  // gcd_value, lcm_value
  input logic                             out_tuser   // both_zero
);
  import gal_pkg::*;

  // a stalled result holds its payload
  `GAL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // one request at a time: busy right after an accept
  `GAL_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // both operands zero gives gcd 0 and lcm 0
  `GAL_ASSERT_SAME(a_zero_result, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0)

  // any other pair has a nonzero gcd
  `GAL_ASSERT_SAME(a_gcd_nonzero, clk, rst_n, out_tvalid && !out_tuser, out_tdata[FIELD_W-1:0] != '0)

endmodule

bind gcd_and_lcm_unit gal_checker u_gal_checker (.*);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// GCD and LCM unit testbench
// Sends operand pairs to the unit over the request stream and checks every
// result against an independent Euclid gcd and (a / gcd) * b lcm prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gal_pkg::*;

  localparam int unsigned OPERAND_WIDTH   = 32;
  localparam int unsigned RANDOM_REQUESTS = 1630;
  // Random request indexes run with both sides idle-free in these windows.
  localparam int unsigned CALM_START      = 700;
  localparam int unsigned CALM_END        = 850;
  localparam int unsigned CALM_TAIL       = 150;
  // Allowance for the slowest request, with ample margin.
  localparam int unsigned STUCK_LIMIT     = 8000;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned MAX_REPORTS     = 10;

  // One predicted result, with the operands kept for mismatch reports.
  typedef struct {
    bit [FIELD_W-1:0] operand_a;
    bit [FIELD_W-1:0] operand_b;
    bit [FIELD_W-1:0] gcd_value;
    bit [LCM_W-1:0]   lcm_value;
    bit               both_zero;
  } gcd_lcm_t;

  // Scoreboard: holds the predicted gcd/lcm results in request order.
  class gcd_lcm_scoreboard;
    gcd_lcm_t    awaited_results[$];
    int unsigned failures;

    static function gcd_lcm_t predict_gcd_lcm(bit [FIELD_W-1:0] a_in, bit [FIELD_W-1:0] b_in);
      gcd_lcm_t      res;
      bit [63:0]     mask;
      bit [63:0]     x;
      bit [63:0]     y;
      bit [63:0]     rem;
      bit [63:0]     a_used;
      bit [63:0]     b_used;
      int            step;
      mask = (OPERAND_WIDTH >= 64) ? '1 : ((64'd1 << OPERAND_WIDTH) - 64'd1);
      a_used = {32'd0, a_in} & mask;
      b_used = {32'd0, b_in} & mask;
      res.operand_a = a_in;
      res.operand_b = b_in;
      res.both_zero = (a_used == 0) && (b_used == 0);
      if (res.both_zero) begin
        res.gcd_value = '0;
        res.lcm_value = '0;
      end else begin
        x = a_used;
        y = b_used;
        for (step = 0; step < 128 && y != 0; step++) begin
          rem = x % y;
          x = y;
          y = rem;
        end
        res.gcd_value = x[FIELD_W-1:0];
        res.lcm_value = (a_used / x) * b_used;
      end
      return res;
    endfunction

    function void note_request(bit [FIELD_W-1:0] a_in, bit [FIELD_W-1:0] b_in);
      awaited_results.push_back(predict_gcd_lcm(a_in, b_in));
    endfunction

    function void check_result(logic [FIELD_W-1:0] gcd_got, logic [LCM_W-1:0] lcm_got,
                               logic zero_got);
      gcd_lcm_t want;
      if (awaited_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result with no request pending: gcd %h lcm %h both_zero %b",
                   gcd_got, lcm_got, zero_got);
        return;
      end
      want = awaited_results.pop_front();
      if (gcd_got !== want.gcd_value || lcm_got !== want.lcm_value ||
          zero_got !== want.both_zero) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("mismatch a=%h b=%h: gcd exp %h got %h, lcm exp %h got %h, zero exp %b got %b",
                   want.operand_a, want.operand_b, want.gcd_value, gcd_got,
                   want.lcm_value, lcm_got, want.both_zero, zero_got);
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  gcd_lcm_scoreboard sb;
  bit                calm = 1'b0;   // no idling on either side while set
  int                stall_left = 0;
  int unsigned       stuck_cycles = 0;

  gcd_and_lcm_unit #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  // Fibonacci pairs are the deepest case for Euclid's remainder loop.
  function automatic bit [31:0] fibonacci(int n);
    bit [31:0] prev;
    bit [31:0] cur;
    bit [31:0] nxt;
    prev = 0;
    cur = 1;
    for (int i = 1; i < n; i++) begin
      nxt = prev + cur;
      prev = cur;
      cur = nxt;
    end
    return (n == 0) ? 32'd0 : cur;
  endfunction

  // Draw one operand pair; mix plain random values with shapes that stress
  // shared factors, divisibility, zeros and long Euclid chains.
  function automatic void pick_operands(output bit [31:0] a, output bit [31:0] b);
    int unsigned kind;
    bit [31:0]   g;
    bit [31:0]   t;
    int          n;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      a = $urandom;
      b = $urandom;
    end else if (kind < 45) begin
      g = $urandom_range(1, 65535);
      a = g * $urandom_range(1, 65535);
      b = g * $urandom_range(1, 65535);
    end else if (kind < 60) begin
      a = $urandom_range(0, 1000);
      b = $urandom_range(0, 1000);
    end else if (kind < 68) begin
      a = $urandom;
      b = 0;
    end else if (kind < 70) begin
      a = 0;
      b = 0;
    end else if (kind < 76) begin
      a = $urandom;
      b = a;
    end else if (kind < 84) begin
      a = $urandom_range(1, 65535);
      b = a * $urandom_range(1, 65535);
    end else if (kind < 92) begin
      a = 32'd1 << $urandom_range(0, 31);
      b = $urandom << $urandom_range(0, 31);
    end else begin
      n = $urandom_range(1, 46);
      a = fibonacci(n + 1);
      b = fibonacci(n);
    end
    if ($urandom_range(0, 1) == 1) begin
      t = a;
      a = b;
      b = t;
    end
  endfunction

  // Present one request and hold it until the unit takes it.
  task automatic send_request(bit [31:0] a, bit [31:0] b);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // Drop valid for a short burst; half the time wait for the unit to come
  // ready first so the gap lands while it could take a request.
  task automatic sender_pause();
    int n;
    n = $urandom_range(1, 4);
    @(negedge clk);
    in_tvalid <= 1'b0;
    if ($urandom_range(0, 1) == 1)
      do @(posedge clk); while (in_tready !== 1'b1);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic issue(bit [31:0] a, bit [31:0] b);
    if (!calm && $urandom_range(0, 3) == 0)
      sender_pause();
    send_request(a, b);
  endtask

  // Result side: stall in random bursts, none while calm.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (rst_n && !calm && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Sample both handshakes at the rising edge; note requests, check results
  // and bail out if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(in_tdata[FIELD_W-1:0], in_tdata[IN_TDATA_W-1:FIELD_W]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[FIELD_W-1:0], out_tdata[FIELD_W +: LCM_W], out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bit [31:0] a;
    bit [31:0] b;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zeros, extremes, largest lcm, deepest Euclid chain.
    issue(32'h0000_0000, 32'h0000_0000);
    issue(32'h0000_0000, 32'h0000_0001);
    issue(32'h0000_0001, 32'h0000_0000);
    issue(32'h0000_0000, 32'hFFFF_FFFF);
    issue(32'hFFFF_FFFF, 32'h0000_0000);
    issue(32'h0000_0001, 32'h0000_0001);
    issue(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    issue(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    issue(32'hFFFF_FFFF, 32'h0000_0001);
    issue(32'h0000_0001, 32'hFFFF_FFFF);
    issue(32'h8000_0000, 32'h8000_0000);
    issue(32'h8000_0000, 32'h0000_0001);
    issue(32'h0000_000C, 32'h0000_0012);
    issue(fibonacci(47), fibonacci(46));
    issue(fibonacci(46), fibonacci(47));
    issue(32'hAAAA_AAAA, 32'h5555_5555);
    issue(32'h5555_5555, 32'hAAAA_AAAA);
    issue(32'h0000_0007, 32'h0000_005B);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      calm = (i >= CALM_START && i < CALM_END) || (i >= RANDOM_REQUESTS - CALM_TAIL);
      pick_operands(a, b);
      issue(a, b);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain: wait for every predicted result, then watch for strays.
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.awaited_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
